@@ rtl/core/ctaphid_report_reassembler_assert.svh @@
// ---------------------------------------------------------------------------
// ctaphid_report_reassembler_assert.svh
// Shared assertion macros for the report reassembler RTL.
// ---------------------------------------------------------------------------
`ifndef CTAPHID_REPORT_REASSEMBLER_ASSERT_SVH
`define CTAPHID_REPORT_REASSEMBLER_ASSERT_SVH

// Clocked check, idle while aresetn is low.
`define CTR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that also holds while reset is asserted.
`define CTR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/core/ctr_pkg.sv @@
// ---------------------------------------------------------------------------
// ctr_pkg
// Types and constants shared by the report reassembler modules.
// ---------------------------------------------------------------------------
package ctr_pkg;

    // Default HID report size in bytes (legal range 8..64).
    localparam int REPORT_BYTES_DEFAULT = 64;

    // Header layout.
    localparam int CHAN_BYTES   = 4;   // channel occupies bytes 0..3
    localparam int CMD_POS      = 4;   // command / sequence byte
    localparam int LEN_HI_POS   = 5;
    localparam int LEN_LO_POS   = 6;
    localparam int INIT_HEADER  = 7;   // first payload byte of an initial report
    localparam int CMD_FLAG_BIT = 7;   // set in the command byte of an initial report

    // Output record queue depth (power of two, at least 2).
    localparam int Q_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ABORT    = 2'd2,
        KIND_DROP     = 2'd3
    } ctr_kind_t;

    typedef enum logic [1:0] {
        PH_INIT = 2'd0,
        PH_CONT = 2'd1
    } ctr_phase_t;

    typedef struct packed {
        ctr_kind_t   kind;
        logic [7:0]  data;
        logic [31:0] channel;
        logic [6:0]  command;
        logic [15:0] length;
        logic        last;
    } ctr_rec_t;

    // Up to two records produced by one report byte, in output order.
    typedef struct packed {
        logic [1:0] count;
        ctr_rec_t   first;
        ctr_rec_t   second;
    } ctr_push_t;

endpackage

@@ rtl/core/ctr_parser.sv @@
// ---------------------------------------------------------------------------
// ctr_parser
// Per-byte header decode, sequence checks and record generation.
// ---------------------------------------------------------------------------
module ctr_parser #(
    parameter int REPORT_BYTES = ctr_pkg::REPORT_BYTES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        report_byte,
    input  logic              report_end,
    output ctr_pkg::ctr_push_t push
);

    localparam int POS_W = $clog2(REPORT_BYTES + 1);

    ctr_pkg::ctr_phase_t phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]         chan_reg, chan_next;
    logic [6:0]          cmd_reg, cmd_next;
    logic [15:0]         len_reg, len_next;
    logic [15:0]         recv_reg, recv_next;
    logic [7:0]          seq_reg, seq_next;
    logic                inval_reg, inval_next;

    logic                active;
    logic [POS_W-1:0]    count;
    logic [7:0]          want_byte;
    logic                pay_v;
    logic                end_v;
    ctr_pkg::ctr_kind_t  end_kind;
    ctr_pkg::ctr_rec_t   pay_rec;
    ctr_pkg::ctr_rec_t   end_rec;

    assign active = pos_reg < POS_W'(REPORT_BYTES);
    assign count  = active ? pos_reg + POS_W'(1) : POS_W'(REPORT_BYTES);

    always_comb begin
        case (pos_reg[1:0])
            2'd0:    want_byte = chan_reg[31:24];
            2'd1:    want_byte = chan_reg[23:16];
            2'd2:    want_byte = chan_reg[15:8];
            default: want_byte = chan_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        recv_next  = recv_reg;
        seq_next   = seq_reg;
        inval_next = inval_reg;
        pay_v      = 1'b0;
        end_v      = 1'b0;
        end_kind   = ctr_pkg::KIND_COMPLETE;

        if (fire) begin
            case (phase_reg)
                ctr_pkg::PH_CONT: begin
                    if (active) begin
                        if (pos_reg < POS_W'(ctr_pkg::CHAN_BYTES)) begin
                            if (want_byte != report_byte) begin
                                inval_next = 1'b1;
                            end
                        end else if (pos_reg == POS_W'(ctr_pkg::CMD_POS)) begin
                            if (report_byte[ctr_pkg::CMD_FLAG_BIT] ||
                                report_byte != seq_reg) begin
                                inval_next = 1'b1;
                            end
                        end else if (!inval_reg && recv_reg < len_reg) begin
                            pay_v     = 1'b1;
                            recv_next = recv_reg + 16'd1;
                        end
                    end
                    if (report_end) begin
                        if (inval_next || count != POS_W'(REPORT_BYTES)) begin
                            end_v      = 1'b1;
                            end_kind   = ctr_pkg::KIND_ABORT;
                            phase_next = ctr_pkg::PH_INIT;
                        end else begin
                            seq_next = seq_reg + 8'd1;
                            if (recv_next >= len_next) begin
                                end_v      = 1'b1;
                                end_kind   = ctr_pkg::KIND_COMPLETE;
                                phase_next = ctr_pkg::PH_INIT;
                            end
                        end
                    end
                end
                default: begin
                    if (active) begin
                        if (pos_reg == '0) begin
                            chan_next  = {24'd0, report_byte};
                            recv_next  = '0;
                            inval_next = 1'b0;
                        end else if (pos_reg < POS_W'(ctr_pkg::CHAN_BYTES)) begin
                            chan_next = {chan_reg[23:0], report_byte};
                        end else if (pos_reg == POS_W'(ctr_pkg::CMD_POS)) begin
                            cmd_next = report_byte[6:0];
                            if (!report_byte[ctr_pkg::CMD_FLAG_BIT]) begin
                                inval_next = 1'b1;
                            end
                        end else if (pos_reg == POS_W'(ctr_pkg::LEN_HI_POS)) begin
                            len_next = {report_byte, 8'd0};
                        end else if (pos_reg == POS_W'(ctr_pkg::LEN_LO_POS)) begin
                            len_next = {len_reg[15:8], report_byte};
                        end else if (!inval_reg && recv_reg < len_reg) begin
                            pay_v     = 1'b1;
                            recv_next = recv_reg + 16'd1;
                        end
                    end
                    if (report_end) begin
                        if (count < POS_W'(ctr_pkg::INIT_HEADER) || inval_next) begin
                            end_v    = 1'b1;
                            end_kind = ctr_pkg::KIND_DROP;
                        end else if (recv_next >= len_next) begin
                            end_v    = 1'b1;
                            end_kind = ctr_pkg::KIND_COMPLETE;
                        end else begin
                            phase_next = ctr_pkg::PH_CONT;
                            seq_next   = '0;
                        end
                    end
                end
            endcase

            if (report_end) begin
                pos_next   = '0;
                inval_next = 1'b0;
            end else if (active) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Records carry the message fields as they stand after this byte; a drop record carries zeros.
    always_comb begin
        pay_rec.kind    = ctr_pkg::KIND_PAYLOAD;
        pay_rec.data    = report_byte;
        pay_rec.channel = chan_next;
        pay_rec.command = cmd_next;
        pay_rec.length  = len_next;
        pay_rec.last    = 1'b0;

        end_rec.kind    = end_kind;
        end_rec.data    = '0;
        end_rec.last    = 1'b1;
        if (end_kind == ctr_pkg::KIND_DROP) begin
            end_rec.channel = '0;
            end_rec.command = '0;
            end_rec.length  = '0;
        end else begin
            end_rec.channel = chan_next;
            end_rec.command = cmd_next;
            end_rec.length  = len_next;
        end

        push.count  = 2'(pay_v) + 2'(end_v);
        push.first  = pay_v ? pay_rec : end_rec;
        push.second = end_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ctr_pkg::PH_INIT;
            pos_reg   <= '0;
            chan_reg  <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            recv_reg  <= '0;
            seq_reg   <= '0;
            inval_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            recv_reg  <= recv_next;
            seq_reg   <= seq_next;
            inval_reg <= inval_next;
        end
    end

endmodule

@@ rtl/core/ctr_out_queue.sv @@
// ---------------------------------------------------------------------------
// ctr_out_queue
// Small record queue: up to two writes per cycle, one read per cycle.
// ---------------------------------------------------------------------------
`include "ctaphid_report_reassembler_assert.svh"

module ctr_out_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctr_pkg::ctr_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output ctr_pkg::ctr_rec_t  out_rec
);

    localparam int AW    = $clog2(ctr_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(ctr_pkg::Q_DEPTH + 1);

    ctr_pkg::ctr_rec_t mem [ctr_pkg::Q_DEPTH];

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop;
    logic              byp_first;
    logic              byp_second;
    ctr_pkg::ctr_rec_t out_rec_reg;

    // Room for a worst-case beat (two records).
    assign room      = cnt_reg <= CNT_W'(ctr_pkg::Q_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;

    // A record written this cycle that lands on the next head goes straight out.
    assign byp_first  = (push.count != 2'd0) && (tail_reg == head_next);
    assign byp_second = (push.count == 2'd2) && (tail_reg + AW'(1) == head_next);

    always_comb begin
        head_next = pop ? head_reg + AW'(1) : head_reg;
        tail_next = tail_reg + AW'(push.count);
        cnt_next  = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[tail_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (byp_second) begin
            out_rec_reg <= push.second;
        end else if (byp_first) begin
            out_rec_reg <= push.first;
        end else begin
            out_rec_reg <= mem[head_next];
        end
    end

    assign out_rec = out_rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CTR_ASSERT(a_occupancy_bound, cnt_reg <= CNT_W'(ctr_pkg::Q_DEPTH), "queue overfilled")
    `CTR_ASSERT(a_push_has_room, push.count != 2'd0 |-> room, "push without room")
    `CTR_ASSERT(a_pop_only, (pop && push.count == 2'd0) |=> cnt_reg == $past(cnt_reg) - CNT_W'(1), "pop count slip")
    `CTR_ASSERT(a_ptr_gap, ((tail_reg - head_reg) == AW'(cnt_reg)) || (cnt_reg == CNT_W'(ctr_pkg::Q_DEPTH)), "pointer/count mismatch")

endmodule

@@ rtl/core/ctaphid_report_reassembler.sv @@
// ---------------------------------------------------------------------------
// ctaphid_report_reassembler
// CTAPHID message reassembly from a byte stream of HID reports.
// ---------------------------------------------------------------------------
// Report bytes enter one per beat, s_report_end on the last byte of a report.
// Initial reports (channel, command with bit 7 set, length, data from byte 7)
// and continuation reports (same channel, sequence 0,1,2,..., data from byte
// 5, at least REPORT_BYTES long) are checked on the fly. Payload bytes leave as
// records of kind payload as soon as they arrive; each message then ends with
// a complete or abort record, and a malformed initial report yields a drop
// record. Downstream logic must discard the payload of an aborted message.
// Bytes past REPORT_BYTES in a report are ignored. Throughput: one input beat
// per clock while the output queue has room; a report's last byte can yield
// two records (payload plus end record), which the 4-entry output queue
// absorbs while the output side moves one record per clock when m_ready is
// high. A beat is captured in the input register, and its record then
// reaches the queue's output register once the queue has room.
// ---------------------------------------------------------------------------
module ctaphid_report_reassembler #(
    parameter int REPORT_BYTES = ctr_pkg::REPORT_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_report_byte,
    input  logic        s_report_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_channel_id,
    output logic [6:0]  m_command,
    output logic [15:0] m_message_length,
    output logic        m_run_last
);

    // Input register: holds one beat until the queue can take its records.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    logic               room;
    logic               fire;
    logic               s_take;
    ctr_pkg::ctr_push_t push;
    ctr_pkg::ctr_rec_t  out_rec;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload side of the input register, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_report_byte;
            in_end_reg  <= s_report_end;
        end
    end

    ctr_parser #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .report_byte (in_byte_reg),
        .report_end  (in_end_reg),
        .push        (push)
    );

    ctr_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (out_rec)
    );

    assign m_record_kind    = out_rec.kind;
    assign m_data_byte      = out_rec.data;
    assign m_channel_id     = out_rec.channel;
    assign m_command        = out_rec.command;
    assign m_message_length = out_rec.length;
    assign m_run_last       = out_rec.last;

endmodule

@@ bench/ctaphid_reassembly_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ctaphid_reassembly_checker
// Watches both channels of the report reassembler, predicts its records from
// the accepted report bytes and compares every record leaving on m_*.
// ---------------------------------------------------------------------------
module ctaphid_reassembly_checker #(
    parameter int REPORT_BYTES = ctr_pkg::REPORT_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_report_byte,
    input  logic        s_report_end,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_record_kind,
    input  logic [7:0]  m_data_byte,
    input  logic [31:0] m_channel_id,
    input  logic [6:0]  m_command,
    input  logic [15:0] m_message_length,
    input  logic        m_run_last,

    output int          mismatch_count,
    output int          records_pending,
    output int          payload_seen,
    output int          complete_seen,
    output int          abort_seen,
    output int          drop_seen
);

    // Reassembly state mirrored from the block.
    ctr_pkg::ctr_phase_t asm_phase;
    logic [6:0]          asm_pos;
    logic [31:0]         asm_channel;
    logic [6:0]          asm_command;
    logic [15:0]         asm_length;
    logic [15:0]         asm_received;
    logic [7:0]          asm_seq;
    logic                asm_bad;

    ctr_pkg::ctr_rec_t   expected_records[$];

    function automatic ctr_pkg::ctr_rec_t form_record(input ctr_pkg::ctr_kind_t kind,
                                                      input logic [7:0] data,
                                                      input logic with_msg);
        ctr_pkg::ctr_rec_t r;
        r.kind    = kind;
        r.data    = data;
        r.channel = with_msg ? asm_channel : 32'd0;
        r.command = with_msg ? asm_command : 7'd0;
        r.length  = with_msg ? asm_length : 16'd0;
        r.last    = (kind != ctr_pkg::KIND_PAYLOAD);
        return r;
    endfunction

    task automatic reassemble_byte(input logic [7:0] b, input logic at_end);
        int pos;
        bit active;
        int count;
        pos    = asm_pos;
        active = pos < REPORT_BYTES;
        count  = active ? pos + 1 : REPORT_BYTES;

        if (asm_phase == ctr_pkg::PH_INIT) begin
            if (active) begin
                if (pos == 0) begin
                    asm_channel  = {24'd0, b};
                    asm_received = 16'd0;
                    asm_bad      = 1'b0;
                end else if (pos < ctr_pkg::CHAN_BYTES) begin
                    asm_channel = {asm_channel[23:0], b};
                end else if (pos == ctr_pkg::CMD_POS) begin
                    asm_command = b[6:0];
                    if (!b[ctr_pkg::CMD_FLAG_BIT])
                        asm_bad = 1'b1;
                end else if (pos == ctr_pkg::LEN_HI_POS) begin
                    asm_length = {b, 8'd0};
                end else if (pos == ctr_pkg::LEN_LO_POS) begin
                    asm_length[7:0] = b;
                end else if (!asm_bad && asm_received < asm_length) begin
                    expected_records.push_back(form_record(ctr_pkg::KIND_PAYLOAD, b, 1'b1));
                    asm_received++;
                end
            end
            if (at_end) begin
                if (count < ctr_pkg::INIT_HEADER || asm_bad) begin
                    expected_records.push_back(form_record(ctr_pkg::KIND_DROP, 8'd0, 1'b0));
                end else if (asm_received >= asm_length) begin
                    expected_records.push_back(form_record(ctr_pkg::KIND_COMPLETE, 8'd0, 1'b1));
                end else begin
                    asm_phase = ctr_pkg::PH_CONT;
                    asm_seq   = 8'd0;
                end
            end
        end else begin
            if (active) begin
                if (pos < ctr_pkg::CHAN_BYTES) begin
                    if (asm_channel[8*(3-pos) +: 8] != b)
                        asm_bad = 1'b1;
                end else if (pos == ctr_pkg::CMD_POS) begin
                    if (b[ctr_pkg::CMD_FLAG_BIT] || b != asm_seq)
                        asm_bad = 1'b1;
                end else if (!asm_bad && asm_received < asm_length) begin
                    expected_records.push_back(form_record(ctr_pkg::KIND_PAYLOAD, b, 1'b1));
                    asm_received++;
                end
            end
            if (at_end) begin
                if (asm_bad || count != REPORT_BYTES) begin
                    expected_records.push_back(form_record(ctr_pkg::KIND_ABORT, 8'd0, 1'b1));
                    asm_phase = ctr_pkg::PH_INIT;
                end else begin
                    asm_seq++;
                    if (asm_received >= asm_length) begin
                        expected_records.push_back(
                            form_record(ctr_pkg::KIND_COMPLETE, 8'd0, 1'b1));
                        asm_phase = ctr_pkg::PH_INIT;
                    end
                end
            end
        end

        if (at_end) begin
            asm_pos = 7'd0;
            asm_bad = 1'b0;
        end else if (active) begin
            asm_pos = 7'(pos + 1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_record();
        ctr_pkg::ctr_rec_t want;
        case (m_record_kind)
            ctr_pkg::KIND_PAYLOAD:  payload_seen++;
            ctr_pkg::KIND_COMPLETE: complete_seen++;
            ctr_pkg::KIND_ABORT:    abort_seen++;
            default:                drop_seen++;
        endcase
        if (expected_records.size() == 0) begin
            mismatch_count++;
            $display("%0t: record with none expected, expected none, actual kind %0d",
                     $time, m_record_kind);
            return;
        end
        want = expected_records.pop_front();
        check_field("record_kind", 32'(want.kind), 32'(m_record_kind));
        check_field("data_byte", 32'(want.data), 32'(m_data_byte));
        check_field("channel_id", want.channel, m_channel_id);
        check_field("command", 32'(want.command), 32'(m_command));
        check_field("message_length", 32'(want.length), 32'(m_message_length));
        check_field("run_last", 32'(want.last), 32'(m_run_last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            asm_phase      = ctr_pkg::PH_INIT;
            asm_pos        = 7'd0;
            asm_channel    = 32'd0;
            asm_command    = 7'd0;
            asm_length     = 16'd0;
            asm_received   = 16'd0;
            asm_seq        = 8'd0;
            asm_bad        = 1'b0;
            expected_records.delete();
            mismatch_count = 0;
            payload_seen   = 0;
            complete_seen  = 0;
            abort_seen     = 0;
            drop_seen      = 0;
        end else begin
            // Input side first: a record can never leave in the beat that causes it.
            if (s_valid && s_ready)
                reassemble_byte(s_report_byte, s_report_end);
            if (m_valid && m_ready)
                check_record();
        end
        records_pending = expected_records.size();
    end

endmodule

@@ bench/tb_ctaphid_report_reassembler.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ctaphid_report_reassembler
// Self-checking bench for the CTAPHID report reassembler.
// ---------------------------------------------------------------------------
// Feeds HID report bytes (directed header corner cases, then randomized
// messages built from initial and continuation reports, with injected header,
// sequence and length faults, oversize and short reports and raw noise) under
// three sender/receiver idle mixes. A checker beside the block predicts every
// record and compares it field by field; this module only drives and decides.
// ---------------------------------------------------------------------------
module tb_ctaphid_report_reassembler;

    localparam int RANDOM_BEATS   = 1050;   // random report bytes, split over 3 mixes
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side
    localparam int TAIL_CYCLES    = 16;     // drain margin at the end, be generous
    localparam int MAX_CONTS      = 4;      // continuations per random message

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_report_byte = 8'd0;
    logic        s_report_end  = 1'b0;

    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_record_kind;
    logic [7:0]  m_data_byte;
    logic [31:0] m_channel_id;
    logic [6:0]  m_command;
    logic [15:0] m_message_length;
    logic        m_run_last;

    int          mismatch_count;
    int          records_pending;
    int          payload_seen;
    int          complete_seen;
    int          abort_seen;
    int          drop_seen;

    // Stimulus knobs. Receiver knobs are written with NBAs from the stimulus
    // process, so the receiver process reads them at a later negedge.
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic        hold_trigger   = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;
    int          beats_sent     = 0;
    int          idle_cycles    = 0;

    logic [7:0]  report_buf[$];

    always #5ns aclk = ~aclk;

    ctaphid_report_reassembler u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_report_byte    (s_report_byte),
        .s_report_end     (s_report_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_data_byte      (m_data_byte),
        .m_channel_id     (m_channel_id),
        .m_command        (m_command),
        .m_message_length (m_message_length),
        .m_run_last       (m_run_last)
    );

    ctaphid_reassembly_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_report_byte    (s_report_byte),
        .s_report_end     (s_report_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_data_byte      (m_data_byte),
        .m_channel_id     (m_channel_id),
        .m_command        (m_command),
        .m_message_length (m_message_length),
        .m_run_last       (m_run_last),
        .mismatch_count   (mismatch_count),
        .records_pending  (records_pending),
        .payload_seen     (payload_seen),
        .complete_seen    (complete_seen),
        .abort_seen       (abort_seen),
        .drop_seen        (drop_seen)
    );

    // Receiver: random back-pressure, or a long hold-off when the stimulus
    // toggles hold_trigger. The hold is counted here, not in the sender.
    always @(negedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: any stretch with no beat accepted on either channel that is
    // longer than the hold-off plus worst random stalls means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d records still expected",
                     $time, WATCHDOG_LIMIT, records_pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One report byte. Entered at a negedge, returns at the negedge after the
    // beat is taken; s_valid is left high so back-to-back beats never drop
    // and re-raise it in one step. Callers that pause lower it themselves.
    task automatic drive_beat(input logic [7:0] value, input logic last_of_report);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_report_byte <= value;
        s_report_end  <= last_of_report;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_report();
        for (int i = 0; i < report_buf.size(); i++)
            drive_beat(report_buf[i], i == report_buf.size() - 1);
    endtask

    // Initial report: channel big-endian, command, length big-endian, then
    // random payload; n_bytes below 7 truncates the header itself.
    task automatic build_initial(input logic [31:0] chan, input logic [7:0] cmd,
                                 input logic [15:0] len, input int n_bytes);
        report_buf.delete();
        for (int i = 0; i < n_bytes; i++) begin
            if (i < ctr_pkg::CHAN_BYTES)
                report_buf.push_back(chan[8*(3-i) +: 8]);
            else if (i == ctr_pkg::CMD_POS)
                report_buf.push_back(cmd);
            else if (i == ctr_pkg::LEN_HI_POS)
                report_buf.push_back(len[15:8]);
            else if (i == ctr_pkg::LEN_LO_POS)
                report_buf.push_back(len[7:0]);
            else
                report_buf.push_back(8'($urandom));
        end
    endtask

    task automatic build_cont(input logic [31:0] chan, input logic [7:0] seq_byte,
                              input int n_bytes);
        report_buf.delete();
        for (int i = 0; i < n_bytes; i++) begin
            if (i < ctr_pkg::CHAN_BYTES)
                report_buf.push_back(chan[8*(3-i) +: 8]);
            else if (i == ctr_pkg::CMD_POS)
                report_buf.push_back(seq_byte);
            else
                report_buf.push_back(8'($urandom));
        end
    endtask

    // Sender pause: stop offering and let every predicted record drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (records_pending != 0)
            @(negedge aclk);
    endtask

    // Mostly well-formed messages with random content; a minority carries a
    // header fault, a continuation fault, odd report lengths, or is noise.
    task automatic send_random_message();
        logic [31:0] chan;
        logic [7:0]  cmd;
        logic [15:0] len;
        int          init_len;
        int          payload_room;
        int          remaining;
        int          seq;
        int          pick;
        int          fault;
        int          cut;

        pick = $urandom_range(99);
        if (pick < 8) begin
            // raw noise report, random length including oversize
            report_buf.delete();
            repeat ($urandom_range(1, 70))
                report_buf.push_back(8'($urandom));
            send_report();
            return;
        end

        pick = $urandom_range(9);
        chan = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        cmd  = {($urandom_range(9) != 0), 7'($urandom)};

        pick = $urandom_range(99);
        if (pick < 35)
            len = 16'($urandom_range(0, 57));
        else if (pick < 80)
            len = 16'($urandom_range(58, 175));
        else if (pick < 95)
            len = 16'($urandom_range(176, 234));
        else
            len = 16'($urandom);   // usually left open, broken by the next message

        pick = $urandom_range(99);
        if (pick < 80)
            init_len = ctr_pkg::REPORT_BYTES_DEFAULT;
        else if (pick < 90)
            init_len = $urandom_range(ctr_pkg::INIT_HEADER,
                                      ctr_pkg::REPORT_BYTES_DEFAULT - 1);
        else if (pick < 95)
            init_len = $urandom_range(1, ctr_pkg::INIT_HEADER - 1);
        else
            init_len = $urandom_range(ctr_pkg::REPORT_BYTES_DEFAULT + 1,
                                      ctr_pkg::REPORT_BYTES_DEFAULT + 8);

        build_initial(chan, cmd, len, init_len);
        send_report();
        if (init_len < ctr_pkg::INIT_HEADER || !cmd[ctr_pkg::CMD_FLAG_BIT])
            return;   // dropped report

        payload_room = ((init_len > ctr_pkg::REPORT_BYTES_DEFAULT) ?
                        ctr_pkg::REPORT_BYTES_DEFAULT : init_len) - ctr_pkg::INIT_HEADER;
        remaining = (len > payload_room) ? len - payload_room : 0;
        seq = 0;
        while (remaining > 0 && seq < MAX_CONTS) begin
            build_cont(chan, 8'(seq), ctr_pkg::REPORT_BYTES_DEFAULT);
            fault = $urandom_range(99);
            if (fault < 3) begin
                // flip one bit of the channel
                cut = $urandom_range(0, ctr_pkg::CHAN_BYTES - 1);
                report_buf[cut] = report_buf[cut] ^ 8'(1 << $urandom_range(0, 7));
            end else if (fault < 5) begin
                report_buf[ctr_pkg::CMD_POS] =
                    report_buf[ctr_pkg::CMD_POS] ^ 8'(1 << $urandom_range(0, 6));
            end else if (fault < 6) begin
                report_buf[ctr_pkg::CMD_POS] = report_buf[ctr_pkg::CMD_POS] | 8'h80;
            end else if (fault < 8) begin
                // short continuation, abort only known at its end
                cut = $urandom_range(1, ctr_pkg::REPORT_BYTES_DEFAULT - 1);
                while (report_buf.size() > cut)
                    void'(report_buf.pop_back());
            end else if (fault < 12) begin
                // oversize: tail bytes are ignored, report still counts as full
                repeat ($urandom_range(1, 8))
                    report_buf.push_back(8'($urandom));
            end
            send_report();
            if (fault < 8)
                return;
            remaining = remaining - ((remaining > 59) ? 59 : remaining);
            seq++;
        end
    endtask

    initial begin
        int phase_end;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed header corner cases ----
        // short initial report (3 bytes) -> drop
        build_initial(32'hFF00_FF00, 8'h80, 16'd0, 3);
        send_report();
        // command bit clear, all-ones channel and length -> drop, no payload
        build_initial(32'hFFFF_FFFF, 8'h7F, 16'hFFFF, 7);
        send_report();
        // header only, declared length zero -> immediate complete
        build_initial(32'h0000_0000, 8'h80, 16'd0, 7);
        send_report();
        // one payload byte, one extra byte past the length is not emitted
        build_initial(32'hFFFF_FFFF, 8'hFF, 16'd1, 9);
        report_buf[7] = 8'hFF;
        report_buf[8] = 8'h00;
        send_report();
        wait_drained();

        // ---- mix 1: light sender gaps, heavy receiver stalls ----
        src_idle_pct = 8;
        sink_stall_pct <= 48;
        phase_end = beats_sent + RANDOM_BEATS / 3;
        repeat (3)
            send_random_message();
        // Long receiver hold-off while a full report is offered: the output
        // queue fills and s_ready must drop.
        wait_drained();
        hold_trigger <= ~hold_trigger;
        @(negedge aclk);
        build_initial(32'h1234_5678, 8'h90, 16'd57, ctr_pkg::REPORT_BYTES_DEFAULT);
        send_report();
        while (beats_sent < phase_end)
            send_random_message();
        wait_drained();

        // ---- mix 2: heavy sender gaps, light receiver stalls ----
        src_idle_pct = 48;
        sink_stall_pct <= 8;
        phase_end = beats_sent + RANDOM_BEATS / 3;
        while (beats_sent < phase_end)
            send_random_message();
        wait_drained();

        // ---- mix 3: full rate both sides ----
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        phase_end = beats_sent + RANDOM_BEATS / 3;
        while (beats_sent < phase_end)
            send_random_message();

        // ---- drain and verdict ----
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Run covered %0d report bytes; out: %0d payload, %0d complete, %0d abort",
                 beats_sent, payload_seen, complete_seen, abort_seen);
        $display("and %0d drop; header and continuation faults, odd sizes, stalls, hold-off",
                 drop_seen);
        if (records_pending != 0)
            $display("%0t: %0d expected records never arrived", $time, records_pending);
        if (mismatch_count == 0 && records_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
